>>> rtl/core/dpct_pkg.sv
// Package for the disc pair collision time block: widths, status codes and
// the record that passes from the classifier to the time unit.
// No dependencies.
`timescale 1ns / 1ps

package dpct_pkg;

    localparam int COORD_BITS     = 24;
    localparam int TIME_FRAC_BITS = 16;
    localparam int TIME_BITS      = 40;
    localparam int TOL_W          = 24;

    localparam int DIFF_W  = COORD_BITS + 1;   // position and velocity differences
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int DOT_W   = PROD_W + 1;       // dot products, signed
    localparam int E_W     = DOT_W + 1;        // drdr - sigma^2
    localparam int HALF_W  = DIFF_W;
    localparam int MAG_W   = 2 * HALF_W;       // magnitudes fed to split multiplies
    localparam int WIDE_W  = 2 * MAG_W;
    localparam int D_W     = WIDE_W + 2;       // discriminant, signed, even width
    localparam int ROOT_W  = D_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int N_W     = DOT_W + 2;
    localparam int SHIFT_W = TIME_BITS - TIME_FRAC_BITS;
    localparam int CMP_W   = DOT_W + SHIFT_W;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(2814750);

    typedef enum logic [1:0] {
        ST_HIT       = 2'd0,
        ST_NEVER     = 2'd1,
        ST_OVERLAP   = 2'd2,
        ST_SATURATED = 2'd3
    } status_t;

    typedef struct packed {
        status_t                 status;
        logic                    need;     // time still to be worked out
        logic signed [D_W-1:0]   d;
        logic [DOT_W-1:0]        ndvdr;    // -dvdr
        logic [DOT_W-1:0]        dvdv;
    } work_t;

endpackage

>>> rtl/core/dpct_if.sv
// Channel interfaces of the disc pair collision time block.
// Depends on dpct_pkg for the coordinate and time widths.
`timescale 1ns / 1ps

interface dpct_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  same_particle;
    logic [dpct_pkg::COORD_BITS-1:0]        a_pos_x;
    logic [dpct_pkg::COORD_BITS-1:0]        a_pos_y;
    logic signed [dpct_pkg::COORD_BITS-1:0] a_vel_x;
    logic signed [dpct_pkg::COORD_BITS-1:0] a_vel_y;
    logic [dpct_pkg::COORD_BITS-1:0]        a_radius;
    logic [dpct_pkg::COORD_BITS-1:0]        b_pos_x;
    logic [dpct_pkg::COORD_BITS-1:0]        b_pos_y;
    logic signed [dpct_pkg::COORD_BITS-1:0] b_vel_x;
    logic signed [dpct_pkg::COORD_BITS-1:0] b_vel_y;
    logic [dpct_pkg::COORD_BITS-1:0]        b_radius;

    modport source (output valid, same_particle, a_pos_x, a_pos_y, a_vel_x, a_vel_y,
                    a_radius, b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius,
                    input ready);
    modport sink (input valid, same_particle, a_pos_x, a_pos_y, a_vel_x, a_vel_y,
                  a_radius, b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius,
                  output ready);
endinterface

interface dpct_out_if;
    logic                           valid;
    logic                           ready;
    logic [dpct_pkg::TIME_BITS-1:0] hit_time;
    logic [1:0]                     status;

    modport source (output valid, hit_time, status, input ready);
    modport sink (input valid, hit_time, status, output ready);
endinterface

>>> rtl/core/dpct_front.sv
// Front end: accepts disc pairs, forms the dot products and the discriminant
// and classifies each transaction. Depends on dpct_pkg and dpct_in_if.
`timescale 1ns / 1ps

module dpct_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [dpct_pkg::TOL_W-1:0] tol,
    dpct_in_if.sink                   pair,
    output logic                      push,
    output dpct_pkg::work_t           push_data,
    input  logic                      full
);
    import dpct_pkg::*;

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // stage 1
    logic                     same1_reg;
    logic signed [DIFF_W-1:0] dx1_reg, dy1_reg, dvx1_reg, dvy1_reg;
    logic [DIFF_W-1:0]        sig1_reg;
    // stage 2
    logic                     same2_reg;
    logic signed [PROD_W-1:0] pxv2_reg, pyv2_reg, pvx2_reg, pvy2_reg, pxx2_reg, pyy2_reg;
    logic [PROD_W-1:0]        sg2_reg;
    // stage 3
    logic                     same3_reg, sep3_reg, zero3_reg, ovl3_reg;
    logic signed [DOT_W-1:0]  dvdr3_reg, dvdv3_reg;
    logic signed [E_W-1:0]    e3_reg;
    logic signed [DOT_W-1:0]  dvdr_next, dvdv_next, drdr_next;
    logic signed [E_W-1:0]    e_next, slack_next;
    // stage 4
    logic                     same4_reg, sep4_reg, zero4_reg, ovl4_reg, eneg4_reg;
    logic [DOT_W-1:0]         ndvdr4_reg, dvdv4_reg;
    logic [MAG_W-1:0]         a_hh4_reg, a_hl4_reg, a_ll4_reg;
    logic [MAG_W-1:0]         b_hh4_reg, b_hl4_reg, b_lh4_reg, b_ll4_reg;
    logic [MAG_W-1:0]         ma_next, me_next;
    logic [DOT_W-1:0]         neg_dvdr;
    logic [E_W-1:0]           neg_e;
    // stage 5
    logic                     same5_reg, sep5_reg, zero5_reg, ovl5_reg, eneg5_reg;
    logic [DOT_W-1:0]         ndvdr5_reg, dvdv5_reg;
    logic [WIDE_W-1:0]        a5_reg, b5_reg;
    // stage 6
    work_t                    w6_reg, w_next;
    logic signed [D_W-1:0]    d_next;

    assign en         = !v6_reg || !full;
    assign push       = v6_reg && !full;
    assign push_data  = w6_reg;
    assign pair.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pair.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_comb
    begin
        dvdr_next  = DOT_W'(pxv2_reg) + DOT_W'(pyv2_reg);
        dvdv_next  = DOT_W'(pvx2_reg) + DOT_W'(pvy2_reg);
        drdr_next  = DOT_W'(pxx2_reg) + DOT_W'(pyy2_reg);
        e_next     = E_W'(drdr_next) - $signed({{(E_W-PROD_W){1'b0}}, sg2_reg});
        slack_next = e_next + $signed({{(E_W-TOL_W){1'b0}}, tol});
        neg_dvdr   = DOT_W'(-dvdr3_reg);
        neg_e      = E_W'(-e3_reg);
        ma_next    = dvdr3_reg[DOT_W-1] ? neg_dvdr[MAG_W-1:0] : dvdr3_reg[MAG_W-1:0];
        me_next    = e3_reg[E_W-1] ? neg_e[MAG_W-1:0] : e3_reg[MAG_W-1:0];
    end

    always_comb
    begin
        d_next = eneg5_reg ? ($signed({2'b00, a5_reg}) + $signed({2'b00, b5_reg}))
                           : ($signed({2'b00, a5_reg}) - $signed({2'b00, b5_reg}));
        w_next.d     = d_next;
        w_next.ndvdr = ndvdr5_reg;
        w_next.dvdv  = dvdv5_reg;
        w_next.need  = 1'b0;
        priority if (same5_reg || sep5_reg || zero5_reg)
            w_next.status = ST_NEVER;
        else if (ovl5_reg)
            w_next.status = ST_OVERLAP;
        else if (d_next[D_W-1])
            w_next.status = ST_NEVER;
        else
        begin
            w_next.status = ST_HIT;
            w_next.need   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            same1_reg <= pair.same_particle;
            dx1_reg   <= $signed({1'b0, pair.b_pos_x}) - $signed({1'b0, pair.a_pos_x});
            dy1_reg   <= $signed({1'b0, pair.b_pos_y}) - $signed({1'b0, pair.a_pos_y});
            dvx1_reg  <= $signed({pair.b_vel_x[COORD_BITS-1], pair.b_vel_x})
                       - $signed({pair.a_vel_x[COORD_BITS-1], pair.a_vel_x});
            dvy1_reg  <= $signed({pair.b_vel_y[COORD_BITS-1], pair.b_vel_y})
                       - $signed({pair.a_vel_y[COORD_BITS-1], pair.a_vel_y});
            sig1_reg  <= {1'b0, pair.a_radius} + {1'b0, pair.b_radius};

            same2_reg <= same1_reg;
            pxv2_reg  <= dx1_reg * dvx1_reg;
            pyv2_reg  <= dy1_reg * dvy1_reg;
            pvx2_reg  <= dvx1_reg * dvx1_reg;
            pvy2_reg  <= dvy1_reg * dvy1_reg;
            pxx2_reg  <= dx1_reg * dx1_reg;
            pyy2_reg  <= dy1_reg * dy1_reg;
            sg2_reg   <= sig1_reg * sig1_reg;

            same3_reg <= same2_reg;
            sep3_reg  <= !dvdr_next[DOT_W-1] && (dvdr_next != '0);
            zero3_reg <= (dvdv_next == '0);
            ovl3_reg  <= slack_next[E_W-1];
            dvdr3_reg <= dvdr_next;
            dvdv3_reg <= dvdv_next;
            e3_reg    <= e_next;

            // split the wide products into half-width partials
            same4_reg  <= same3_reg;
            sep4_reg   <= sep3_reg;
            zero4_reg  <= zero3_reg;
            ovl4_reg   <= ovl3_reg;
            eneg4_reg  <= e3_reg[E_W-1];
            ndvdr4_reg <= neg_dvdr;
            dvdv4_reg  <= dvdv3_reg;
            a_hh4_reg  <= ma_next[MAG_W-1:HALF_W] * ma_next[MAG_W-1:HALF_W];
            a_hl4_reg  <= ma_next[MAG_W-1:HALF_W] * ma_next[HALF_W-1:0];
            a_ll4_reg  <= ma_next[HALF_W-1:0] * ma_next[HALF_W-1:0];
            b_hh4_reg  <= dvdv3_reg[MAG_W-1:HALF_W] * me_next[MAG_W-1:HALF_W];
            b_hl4_reg  <= dvdv3_reg[MAG_W-1:HALF_W] * me_next[HALF_W-1:0];
            b_lh4_reg  <= dvdv3_reg[HALF_W-1:0] * me_next[MAG_W-1:HALF_W];
            b_ll4_reg  <= dvdv3_reg[HALF_W-1:0] * me_next[HALF_W-1:0];

            same5_reg  <= same4_reg;
            sep5_reg   <= sep4_reg;
            zero5_reg  <= zero4_reg;
            ovl5_reg   <= ovl4_reg;
            eneg5_reg  <= eneg4_reg;
            ndvdr5_reg <= ndvdr4_reg;
            dvdv5_reg  <= dvdv4_reg;
            a5_reg     <= {a_hh4_reg, a_ll4_reg} + (WIDE_W'(a_hl4_reg) << (HALF_W + 1));
            b5_reg     <= {b_hh4_reg, b_ll4_reg} + (WIDE_W'(b_hl4_reg) << HALF_W)
                        + (WIDE_W'(b_lh4_reg) << HALF_W);

            w6_reg <= w_next;
        end
    end

endmodule

>>> rtl/core/dpct_fifo.sv
// Two-entry queue between the classifier and the time unit.
// Depends on dpct_pkg.
`timescale 1ns / 1ps

module dpct_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dpct_pkg::work_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output dpct_pkg::work_t head
);
    import dpct_pkg::*;

    work_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> rtl/core/dpct_back.sv
// Back end: integer square root of the discriminant one digit a stage, then the
// numerator stage, the time quotient one bit a stage, and the result register.
// Depends on dpct_pkg and dpct_out_if.
`timescale 1ns / 1ps

module dpct_back (
    input  logic            clk,
    input  logic            rst_n,
    output logic            pop,
    input  logic            empty,
    input  dpct_pkg::work_t head,
    dpct_out_if.source      result
);
    import dpct_pkg::*;

    logic en;

    logic              sq_v_reg    [ROOT_W+1];
    work_t             sq_w_reg    [ROOT_W+1];
    logic [REM_W-1:0]  sq_rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root_reg [ROOT_W+1];

    logic                 dv_v_reg    [TIME_BITS+1];
    status_t              dv_st_reg   [TIME_BITS+1];
    logic                 dv_need_reg [TIME_BITS+1];
    logic                 dv_zero_reg [TIME_BITS+1];
    logic                 dv_sat_reg  [TIME_BITS+1];
    logic [DOT_W-1:0]     dv_dvdv_reg [TIME_BITS+1];
    logic [DOT_W-1:0]     dv_rem_reg  [TIME_BITS+1];
    logic [TIME_BITS-1:0] dv_q_reg    [TIME_BITS+1];

    logic                  out_v_reg;
    logic [TIME_BITS-1:0]  out_t_reg;
    status_t               out_s_reg;

    logic signed [N_W-1:0] n_next;
    logic [DOT_W-1:0]      npos_next;
    logic                  sat_next;

    assign en  = !out_v_reg || result.ready;
    assign pop = en && !empty;

    assign result.valid    = out_v_reg;
    assign result.hit_time = out_t_reg;
    assign result.status   = out_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else if (en)
            sq_v_reg[0] <= !empty;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_w_reg[0]    <= head;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // one root digit a stage: bring down two bits of d, try root*4+1
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        logic [REM_W-1:0]  shifted;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb
        begin
            shifted = {sq_rem_reg[k][REM_W-3:0], sq_w_reg[k].d[D_W-1-2*k -: 2]};
            trial   = {1'b0, sq_root_reg[k], 2'b01};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {sq_root_reg[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {sq_root_reg[k][ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[k+1] <= 1'b0;
            else if (en)
                sq_v_reg[k+1] <= sq_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_w_reg[k+1]    <= sq_w_reg[k];
                sq_rem_reg[k+1]  <= rem_next;
                sq_root_reg[k+1] <= root_next;
            end
        end
    end

    // numerator and saturation check
    always_comb
    begin
        n_next    = $signed({2'b00, sq_w_reg[ROOT_W].ndvdr})
                  - $signed({2'b00, sq_root_reg[ROOT_W]});
        npos_next = n_next[DOT_W-1:0];
        sat_next  = {{SHIFT_W{1'b0}}, npos_next}
                  >= {sq_w_reg[ROOT_W].dvdv, {SHIFT_W{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (en)
            dv_v_reg[0] <= sq_v_reg[ROOT_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_st_reg[0]   <= sq_w_reg[ROOT_W].status;
            dv_need_reg[0] <= sq_w_reg[ROOT_W].need;
            dv_zero_reg[0] <= n_next[N_W-1] || (n_next == '0);
            dv_sat_reg[0]  <= sat_next;
            dv_dvdv_reg[0] <= sq_w_reg[ROOT_W].dvdv;
            dv_rem_reg[0]  <= DOT_W'(npos_next >> SHIFT_W);
            dv_q_reg[0]    <= {npos_next[SHIFT_W-1:0], {TIME_FRAC_BITS{1'b0}}};
        end
    end

    // restoring division, one quotient bit a stage
    for (genvar j = 0; j < TIME_BITS; j++)
    begin : g_div
        logic [DOT_W:0]       shifted;
        logic [DOT_W-1:0]     rem_next;
        logic [TIME_BITS-1:0] q_next;

        always_comb
        begin
            shifted = {dv_rem_reg[j], dv_q_reg[j][TIME_BITS-1]};
            if (shifted >= {1'b0, dv_dvdv_reg[j]})
            begin
                rem_next = DOT_W'(shifted - {1'b0, dv_dvdv_reg[j]});
                q_next   = {dv_q_reg[j][TIME_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DOT_W-1:0];
                q_next   = {dv_q_reg[j][TIME_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[j+1] <= 1'b0;
            else if (en)
                dv_v_reg[j+1] <= dv_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_st_reg[j+1]   <= dv_st_reg[j];
                dv_need_reg[j+1] <= dv_need_reg[j];
                dv_zero_reg[j+1] <= dv_zero_reg[j];
                dv_sat_reg[j+1]  <= dv_sat_reg[j];
                dv_dvdv_reg[j+1] <= dv_dvdv_reg[j];
                dv_rem_reg[j+1]  <= rem_next;
                dv_q_reg[j+1]    <= q_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= dv_v_reg[TIME_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            priority if (!dv_need_reg[TIME_BITS])
            begin
                out_t_reg <= '0;
                out_s_reg <= dv_st_reg[TIME_BITS];
            end
            else if (dv_zero_reg[TIME_BITS])
            begin
                out_t_reg <= '0;
                out_s_reg <= ST_HIT;
            end
            else if (dv_sat_reg[TIME_BITS])
            begin
                out_t_reg <= '1;
                out_s_reg <= ST_SATURATED;
            end
            else
            begin
                out_t_reg <= dv_q_reg[TIME_BITS];
                out_s_reg <= ST_HIT;
            end
        end
    end

endmodule

>>> rtl/core/disc_pair_collision_time.sv
// Disc pair collision time predictor, top level.
// Throughput: one transaction per cycle while neither side stalls. Stages from
// acceptance to result valid: six classifier stages, the queue, the square root
// stages, one numerator stage, 40 quotient stages, output.
// Reset clears all valid flags and the queue, and loads overlap_tolerance
// with its default; no transaction is lost across a stall on either side.
`timescale 1ns / 1ps

module disc_pair_collision_time (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [dpct_pkg::TOL_W-1:0] cfg_wdata,
    dpct_in_if.sink                    pair,
    dpct_out_if.source                 result
);
    import dpct_pkg::*;

    logic [TOL_W-1:0] tol_reg;
    logic             push, full, pop, empty;
    work_t            push_data, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_we)
            tol_reg <= cfg_wdata;
    end

    dpct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tol       (tol_reg),
        .pair      (pair),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    dpct_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    dpct_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .pop    (pop),
        .empty  (empty),
        .head   (head),
        .result (result)
    );

endmodule

>>> rtl/core/dpct_checker.sv
// Port-level checks for the disc pair collision time block, bound to the top.
// Depends on dpct_pkg.
`timescale 1ns / 1ps

module dpct_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [dpct_pkg::TIME_BITS-1:0] hit_time,
    input logic [1:0]                     status
);
    import dpct_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit_time) && $stable(status))
        else $error("result changed while stalled");

    a_no_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NEVER || status == ST_OVERLAP) |-> hit_time == '0)
        else $error("time reported with no-hit status");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_SATURATED |-> &hit_time)
        else $error("saturated status without full-scale time");

    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid straight out of reset");

endmodule

bind disc_pair_collision_time dpct_checker u_dpct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .hit_time  (result.hit_time),
    .status    (result.status)
);

>>> bench/disc_pair_collision_time_tb.sv
// Testbench for the disc pair collision time block: directed and random disc pairs,
// predicted contact times and status checked against the result channel.
// Depends on dpct_pkg, dpct_in_if/dpct_out_if and disc_pair_collision_time.
`timescale 1ns / 1ps

class contact_scoreboard;
    logic [39:0] time_q[$];
    dpct_pkg::status_t status_q[$];
    int errors;
    logic [23:0] tolerance;

    function new();
        errors = 0;
        tolerance = dpct_pkg::TOL_RESET;
    endfunction

    // integer square root by digit recurrence
    function automatic logic [127:0] root_of(logic [255:0] v);
        logic [127:0] r;
        logic [255:0] t;
        r = 0;
        for (int b = 79; b >= 0; b--)
        begin
            t = {128'd0, r | (128'd1 << b)};
            if (t * t <= v)
                r = r | (128'd1 << b);
        end
        return r;
    endfunction

    function automatic void note_pair(logic sp, logic [23:0] apx, logic [23:0] apy,
                                      logic signed [23:0] avx, logic signed [23:0] avy,
                                      logic [23:0] ar, logic [23:0] bpx, logic [23:0] bpy,
                                      logic signed [23:0] bvx, logic signed [23:0] bvy,
                                      logic [23:0] br);
        logic signed [255:0] dx, dy, dvx, dvy, sig, dvdr, dvdv, drdr, sig2, disc, n, q;
        logic [39:0] t;
        dpct_pkg::status_t st;
        dx = $signed({1'b0, bpx}) - $signed({1'b0, apx});
        dy = $signed({1'b0, bpy}) - $signed({1'b0, apy});
        dvx = bvx - avx;
        dvy = bvy - avy;
        sig = $signed({1'b0, ar}) + $signed({1'b0, br});
        dvdr = dx * dvx + dy * dvy;
        dvdv = dvx * dvx + dvy * dvy;
        drdr = dx * dx + dy * dy;
        sig2 = sig * sig;
        disc = dvdr * dvdr - dvdv * (drdr - sig2);
        t = 0;
        st = dpct_pkg::ST_NEVER;
        if (sp || dvdr > 0 || dvdv == 0)
            st = dpct_pkg::ST_NEVER;
        else if (drdr < sig2 - $signed({1'b0, tolerance}))
            st = dpct_pkg::ST_OVERLAP;
        else if (disc < 0)
            st = dpct_pkg::ST_NEVER;
        else
        begin
            st = dpct_pkg::ST_HIT;
            n = -dvdr - $signed({128'd0, root_of(disc)});
            if (n > 0)
            begin
                q = (n <<< 16) / dvdv;
                if (q >= (256'sd1 <<< 40))
                begin
                    t = '1;
                    st = dpct_pkg::ST_SATURATED;
                end
                else
                    t = q[39:0];
            end
        end
        time_q.push_back(t);
        status_q.push_back(st);
    endfunction

    function automatic void check_result(logic [39:0] t, logic [1:0] st);
        logic [39:0] et;
        dpct_pkg::status_t es;
        if (time_q.size() == 0)
        begin
            $error("unexpected result hit_time=%0d status=%0d", t, st);
            errors++;
            return;
        end
        et = time_q.pop_front();
        es = status_q.pop_front();
        if (st !== es)
        begin
            $error("status expected %0d actual %0d", es, st);
            errors++;
        end
        if (t !== et)
        begin
            $error("hit_time expected %0d actual %0d", et, t);
            errors++;
        end
    endfunction
endclass

module disc_pair_collision_time_tb;
    import dpct_pkg::*;

    localparam int LATENCY = 100;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [TOL_W-1:0] cfg_wdata;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off;
    longint cycles;

    dpct_in_if pair ();
    dpct_out_if result ();

    disc_pair_collision_time uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pair      (pair.sink),
        .result    (result.source)
    );

    contact_scoreboard board;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        board = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        pair.valid = 1'b0;
        pair.same_particle = 1'b0;
        pair.a_pos_x = '0;
        pair.a_pos_y = '0;
        pair.a_vel_x = '0;
        pair.a_vel_y = '0;
        pair.a_radius = '0;
        pair.b_pos_x = '0;
        pair.b_pos_y = '0;
        pair.b_vel_x = '0;
        pair.b_vel_y = '0;
        pair.b_radius = '0;
        result.ready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 0;
    end

    // receiver: random stalls plus a counted hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result.valid && result.ready)
                board.check_result(result.hit_time, result.status);
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                result.ready <= 1'b0;
            end
            else
                result.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[disc_pair_collision_time] ERROR");
            $finish;
        end
    end

    task automatic write_tolerance(logic [23:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.tolerance = v;
    endtask

    task automatic drain();
        while (board.time_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task automatic send_pair(logic sp, logic [23:0] apx, logic [23:0] apy, logic [23:0] avx,
                             logic [23:0] avy, logic [23:0] ar, logic [23:0] bpx,
                             logic [23:0] bpy, logic [23:0] bvx, logic [23:0] bvy,
                             logic [23:0] br);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pair.valid <= 1'b0;
            @(posedge clk);
        end
        pair.valid <= 1'b1;
        pair.same_particle <= sp;
        pair.a_pos_x <= apx;
        pair.a_pos_y <= apy;
        pair.a_vel_x <= avx;
        pair.a_vel_y <= avy;
        pair.a_radius <= ar;
        pair.b_pos_x <= bpx;
        pair.b_pos_y <= bpy;
        pair.b_vel_x <= bvx;
        pair.b_vel_y <= bvy;
        pair.b_radius <= br;
        @(posedge clk);
        while (!pair.ready)
            @(posedge clk);
        board.note_pair(sp, apx, apy, avx, avy, ar, bpx, bpy, bvx, bvy, br);
    endtask

    task automatic send_idle();
        pair.valid <= 1'b0;
    endtask

    // random pair: mostly approaching discs with moderate radii, some pure noise
    task automatic send_random();
        logic [23:0] apx, apy, bpx, bpy, ar, br;
        logic signed [23:0] avx, avy, bvx, bvy;
        int kind;
        kind = $urandom_range(9);
        apx = $urandom;
        apy = $urandom;
        avx = $urandom;
        avy = $urandom;
        bvx = $urandom;
        bvy = $urandom;
        if (kind < 3)
        begin
            bpx = $urandom;
            bpy = $urandom;
            ar = $urandom_range(8388608);
            br = $urandom_range(8388608);
        end
        else
        begin
            bpx = apx + 24'($urandom_range(4000000)) - 24'd2000000;
            bpy = apy + 24'($urandom_range(4000000)) - 24'd2000000;
            ar = $urandom_range(500000);
            br = $urandom_range(500000);
            // point relative velocity roughly from B towards A
            bvx = avx - 24'($signed(bpx - apx) >>> $urandom_range(6));
            bvy = avy - 24'($signed(bpy - apy) >>> $urandom_range(6));
            if (kind == 9)
            begin
                bvx = avx + 24'($urandom_range(3)) - 24'd1;
                bvy = avy;
            end
        end
        send_pair($urandom_range(19) == 0, apx, apy, avx, avy, ar, bpx, bpy, bvx, bvy, br);
    endtask

    initial
    begin
        cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: same particle, separating, still, overlap, miss, hit, extremes
        send_pair(1, 100, 100, 0, 0, 10, 200, 200, -5, -5, 10);
        send_pair(0, 0, 0, -100, 0, 5, 1000, 0, 100, 0, 5);
        send_pair(0, 0, 0, 77, 77, 5, 1000, 0, 77, 77, 5);
        send_pair(0, 1000, 1000, 0, 0, 8388608, 1200, 1000, -10, 0, 8388608);
        send_pair(0, 0, 0, 0, 0, 10, 1000000, 5000000, -1000, 0, 10);
        send_pair(0, 0, 0, 0, 0, 1000, 1000000, 0, -1000, 0, 1000);
        send_pair(0, 0, 0, 0, 0, 8, 24'hFFFFFF, 0, 1, 0, 8);
        send_pair(0, 24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 8388608,
                  0, 0, 24'h800000, 24'h800000, 8388608);
        send_pair(0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 0, 24'hFFFFFF, 24'hFFFFFF,
                  24'h800000, 24'h800000, 0);
        send_pair(0, 500, 500, 0, 0, 100, 700, 500, -3, 0, 100);
        send_pair(0, 0, 0, 0, 0, 100, 199, 0, -5, 0, 100);
        send_pair(0, 24'hAAAAAA, 24'h555555, 24'h2AAAAA, 24'hD55555, 24'h555555,
                  24'h555555, 24'hAAAAAA, 24'hD55555, 24'h2AAAAA, 24'h2AAAAA);
        send_idle();
        drain();

        // four tolerance settings, including both extremes
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_tolerance(24'd0);
                1: write_tolerance(24'hFFFFFF);
                2: write_tolerance(24'($urandom));
                default: write_tolerance(TOL_RESET);
            endcase
            send_pair(0, 0, 0, 0, 0, 100, 199, 0, -5, 0, 100);
            send_pair(0, 0, 0, 0, 0, 2000, 3990, 0, -5, 0, 2000);
            for (int i = 0; i < 450; i++)
            begin
                case (i / 150)
                    0: begin send_idle_pct = 21; recv_idle_pct = 75; end
                    1: begin send_idle_pct = 75; recv_idle_pct = 21; end
                    default: begin send_idle_pct = 0; recv_idle_pct = 0; end
                endcase
                if (phase == 1 && i == 320)
                    hold_off = 400;
                send_random();
            end
            send_idle();
            drain();
        end

        if (board.errors == 0 && board.time_q.size() == 0)
            $display("[disc_pair_collision_time] OK");
        else
            $display("[disc_pair_collision_time] ERROR");
        $finish;
    end
endmodule
